// ===== rtl/core/u8d_pkg.sv =====
package u8d_pkg;

   localparam int unsigned CODE_POINT_WIDTH = 21;
   localparam int unsigned BITS_WIDTH       = 7;
   localparam int unsigned QUEUE_DEPTH      = 2;
   localparam int unsigned QUEUE_PTR_WIDTH  = 1;
   localparam int unsigned QUEUE_CNT_WIDTH  = 2;

   typedef logic [2:0] u8d_kind_type;

   localparam u8d_kind_type KIND_CONT  = 3'd0;
   localparam u8d_kind_type KIND_LEAD1 = 3'd1;
   localparam u8d_kind_type KIND_LEAD2 = 3'd2;
   localparam u8d_kind_type KIND_LEAD3 = 3'd3;
   localparam u8d_kind_type KIND_LEAD4 = 3'd4;
   localparam u8d_kind_type KIND_BAD   = 3'd5;

   localparam logic [CODE_POINT_WIDTH-1:0] CP_REPLACEMENT = 21'h00FFFD;
   localparam logic [CODE_POINT_WIDTH-1:0] CP_SURR_LO     = 21'h00D800;
   localparam logic [CODE_POINT_WIDTH-1:0] CP_SURR_HI     = 21'h00DFFF;
   localparam logic [CODE_POINT_WIDTH-1:0] CP_MAX         = 21'h10FFFF;
   localparam logic [CODE_POINT_WIDTH-1:0] MAX_LEN1       = 21'h00007F;
   localparam logic [CODE_POINT_WIDTH-1:0] MAX_LEN2       = 21'h0007FF;
   localparam logic [CODE_POINT_WIDTH-1:0] MAX_LEN3       = 21'h00FFFF;
   localparam logic [CODE_POINT_WIDTH-1:0] MIN_LEN2       = 21'h000080;
   localparam logic [CODE_POINT_WIDTH-1:0] MIN_LEN3       = 21'h000800;
   localparam logic [CODE_POINT_WIDTH-1:0] MIN_LEN4       = 21'h010000;

   // One classified byte as it travels from the front to the back.
   typedef struct packed {
      u8d_kind_type          kind;
      logic [BITS_WIDTH-1:0] bits;
      logic                  last;
   } u8d_item_type;

   // A completed sequence is accepted only when it is in range for its length,
   // is not a surrogate and is not the replacement character.
   function automatic logic value_ok(input logic [CODE_POINT_WIDTH-1:0] v,
                                     input logic [2:0] len);
      logic in_range;
      in_range = 1'b0;
      case (len)
         3'd1: in_range = (v <= MAX_LEN1);
         3'd2: in_range = (v >= MIN_LEN2) && (v <= MAX_LEN2);
         3'd3: in_range = (v >= MIN_LEN3) && (v <= MAX_LEN3);
         3'd4: in_range = (v >= MIN_LEN4) && (v <= CP_MAX);
         default: in_range = 1'b0;
      endcase
      return in_range && !((v >= CP_SURR_LO) && (v <= CP_SURR_HI))
             && (v != CP_REPLACEMENT);
   endfunction

endpackage

// ===== rtl/core/u8d_front.sv =====
module u8d_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_last_byte,
   output logic                  q_valid,
   input  logic                  q_pop,
   output u8d_pkg::u8d_item_type q_item
);
   import u8d_pkg::*;

   u8d_item_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0]   count_ff, count_in;
   u8d_item_type                 item;
   logic                         push;

   always_comb begin
      item.last = req_last_byte;
      item.bits = '0;
      if (req_data_byte[7:6] == 2'b10) begin
         item.kind = KIND_CONT;
         item.bits = {1'b0, req_data_byte[5:0]};
      end else if (req_data_byte[7] == 1'b0) begin
         item.kind = KIND_LEAD1;
         item.bits = req_data_byte[6:0];
      end else if (req_data_byte[7:5] == 3'b110) begin
         item.kind = KIND_LEAD2;
         item.bits = {2'b00, req_data_byte[4:0]};
      end else if (req_data_byte[7:4] == 4'b1110) begin
         item.kind = KIND_LEAD3;
         item.bits = {3'b000, req_data_byte[3:0]};
      end else if (req_data_byte[7:3] == 5'b11110) begin
         item.kind = KIND_LEAD4;
         item.bits = {4'b0000, req_data_byte[2:0]};
      end else begin
         item.kind = KIND_BAD;
      end
   end

   assign req_stall = (count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = (q_pop && q_valid) ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !(q_pop && q_valid)) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop && q_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_WIDTH'(QUEUE_DEPTH))
      else $error("queue count exceeds depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !(q_pop && q_valid)) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");
endmodule

// ===== rtl/core/u8d_back.sv =====
module u8d_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  u8d_pkg::u8d_item_type q_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [20:0]           rsp_code_point,
   output logic                  rsp_point_valid,
   output logic                  rsp_string_end
);
   import u8d_pkg::*;

   logic [1:0]                  remaining_ff, remaining_in;
   logic [2:0]                  length_ff, length_in;
   logic [CODE_POINT_WIDTH-1:0] acc_ff, acc_in;
   logic                        skip_ff, skip_in;
   logic                        out_valid_ff, out_valid_in;
   logic [CODE_POINT_WIDTH-1:0] out_cp_ff;
   logic                        out_pv_ff;
   logic                        out_end_ff;
   logic [CODE_POINT_WIDTH-1:0] acc_shift;
   logic [CODE_POINT_WIDTH-1:0] cp;
   logic                        have;

   // The back advances whenever the output register is empty or being drained.
   assign q_pop     = q_valid && (!out_valid_ff || !rsp_stall);
   assign acc_shift = {acc_ff[CODE_POINT_WIDTH-7:0], q_item.bits[5:0]};

   always_comb begin
      remaining_in = remaining_ff;
      length_in    = length_ff;
      acc_in       = acc_ff;
      skip_in      = skip_ff;
      have         = 1'b0;
      cp           = '0;
      case (q_item.kind)
         KIND_CONT: begin
            if (!skip_ff && (remaining_ff != 2'd0)) begin
               remaining_in = remaining_ff - 2'd1;
               acc_in       = acc_shift;
               if (remaining_ff == 2'd1) begin
                  have      = value_ok(acc_shift, length_ff);
                  cp        = acc_shift;
                  length_in = 3'd0;
                  acc_in    = '0;
               end
            end
         end
         default: begin
            skip_in      = 1'b0;
            remaining_in = 2'd0;
            length_in    = 3'd0;
            acc_in       = '0;
            case (q_item.kind)
               KIND_LEAD1: begin
                  have = 1'b1;
                  cp   = CODE_POINT_WIDTH'(q_item.bits);
               end
               KIND_LEAD2: begin
                  acc_in       = CODE_POINT_WIDTH'(q_item.bits);
                  length_in    = 3'd2;
                  remaining_in = 2'd1;
               end
               KIND_LEAD3: begin
                  acc_in       = CODE_POINT_WIDTH'(q_item.bits);
                  length_in    = 3'd3;
                  remaining_in = 2'd2;
               end
               KIND_LEAD4: begin
                  acc_in       = CODE_POINT_WIDTH'(q_item.bits);
                  length_in    = 3'd4;
                  remaining_in = 2'd3;
               end
               default: begin
                  skip_in = 1'b1;
               end
            endcase
         end
      endcase
      if (q_item.last) begin
         remaining_in = 2'd0;
         length_in    = 3'd0;
         acc_in       = '0;
         skip_in      = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (q_pop) begin
         out_valid_in = have || q_item.last;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         length_ff    <= '0;
         acc_ff       <= '0;
         skip_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (q_pop) begin
            remaining_ff <= remaining_in;
            length_ff    <= length_in;
            acc_ff       <= acc_in;
            skip_ff      <= skip_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_cp_ff  <= have ? cp : '0;
         out_pv_ff  <= have;
         out_end_ff <= q_item.last;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_code_point  = out_cp_ff;
   assign rsp_point_valid = out_pv_ff;
   assign rsp_string_end  = out_end_ff;

   a_result_reason: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_pv_ff || out_end_ff))
      else $error("result carries neither a code point nor a string end");

   a_cp_legal: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_pv_ff) |-> ((out_cp_ff <= CP_MAX)
         && !((out_cp_ff >= CP_SURR_LO) && (out_cp_ff <= CP_SURR_HI))
         && (out_cp_ff != CP_REPLACEMENT)))
      else $error("illegal code point delivered");

   a_cp_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_pv_ff) |-> (out_cp_ff == '0))
      else $error("code point not zero on an empty result");

   a_skip_closed: assert property (@(posedge clock) disable iff (reset)
      skip_ff |-> (remaining_ff == 2'd0))
      else $error("sequence open while skipping");
endmodule

// ===== rtl/core/utf8_stream_decoder.sv =====
// UTF-8 stream decoder.
// The request channel (req_valid, req_stall, req_data_byte, req_last_byte)
// takes one byte of a string per request; req_last_byte marks the final byte.
// The response channel (rsp_valid, rsp_stall, rsp_code_point, rsp_point_valid,
// rsp_string_end) delivers one decoded character per completed valid sequence.
// Rejected sequences, stray continuation bytes and bytes after an invalid lead
// give no response. The final byte always gives exactly one response with
// rsp_string_end set, carrying a character only if that byte completed one.
// Throughput is one byte per cycle while nothing stalls: a front stage
// classifies each byte into a two-entry queue, and the back stage decodes one
// queued byte per cycle into an output register unless that register is held.
// When the response side is not stalled, an accepted byte passes from the queue
// into the output register, where rsp_valid is raised if it gives a response.
// While rsp_stall is high the output holds; the queue keeps taking requests
// until it is full, then req_stall rises. req_stall depends only on the queue
// fill, never directly on rsp_stall.
// Synchronous reset empties the queue, drops any held response and clears the
// decoding state, so any partial sequence is lost.
module utf8_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [20:0] rsp_code_point,
   output logic        rsp_point_valid,
   output logic        rsp_string_end
);
   import u8d_pkg::*;

   logic         q_valid;
   logic         q_pop;
   u8d_item_type q_item;

   u8d_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_valid       (q_valid),
      .q_pop         (q_pop),
      .q_item        (q_item)
   );

   u8d_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .q_item          (q_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_point_valid (rsp_point_valid),
      .rsp_string_end  (rsp_string_end)
   );
endmodule

// ===== tb/sv/tb_utf8_stream_decoder.sv =====
`timescale 1ns / 100ps

module tb_utf8_stream_decoder;
   import u8d_pkg::*;

   // Tracks the decoder state alongside the block and holds the responses
   // still owed on the response channel, oldest first.
   class utf8_decode_scoreboard;
      typedef struct packed {
         logic [20:0] code_point;
         logic        point_valid;
         logic        string_end;
      } decoded_point_type;

      logic [1:0]        bytes_left;
      logic [2:0]        seq_len;
      logic [20:0]       partial;
      bit                skipping;
      decoded_point_type points_due[$];
      int                mismatch_count;

      function new();
         clear_decode();
         mismatch_count = 0;
      endfunction

      function void clear_decode();
         bytes_left = '0;
         seq_len    = '0;
         partial    = '0;
         skipping   = 1'b0;
      endfunction

      function u8d_kind_type classify(logic [7:0] b);
         if (b[7:6] == 2'b10) return KIND_CONT;
         if (b[7] == 1'b0) return KIND_LEAD1;
         if (b[7:5] == 3'b110) return KIND_LEAD2;
         if (b[7:4] == 4'b1110) return KIND_LEAD3;
         if (b[7:3] == 5'b11110) return KIND_LEAD4;
         return KIND_BAD;
      endfunction

      // A finished sequence must fit the range of its length, must not be a
      // surrogate and must not be the replacement character.
      function bit scalar_accepted(logic [20:0] v, logic [2:0] n);
         logic [20:0] floor_v;
         logic [20:0] ceil_v;
         case (n)
            3'd1: begin
               floor_v = '0;
               ceil_v  = MAX_LEN1;
            end
            3'd2: begin
               floor_v = MIN_LEN2;
               ceil_v  = MAX_LEN2;
            end
            3'd3: begin
               floor_v = MIN_LEN3;
               ceil_v  = MAX_LEN3;
            end
            3'd4: begin
               floor_v = MIN_LEN4;
               ceil_v  = CP_MAX;
            end
            default: return 1'b0;
         endcase
         if (v < floor_v || v > ceil_v) return 1'b0;
         if (v >= CP_SURR_LO && v <= CP_SURR_HI) return 1'b0;
         return v != CP_REPLACEMENT;
      endfunction

      function void note_request(logic [7:0] b, logic last);
         u8d_kind_type      kind;
         logic              have;
         logic [20:0]       cp;
         decoded_point_type d;
         kind = classify(b);
         have = 1'b0;
         cp   = '0;
         if (kind == KIND_CONT) begin
            if (!skipping && bytes_left != 0) begin
               partial    = {partial[14:0], b[5:0]};
               bytes_left = bytes_left - 2'd1;
               if (bytes_left == 0) begin
                  if (scalar_accepted(partial, seq_len)) begin
                     have = 1'b1;
                     cp   = partial;
                  end
                  seq_len = '0;
                  partial = '0;
               end
            end
         end else begin
            // Any non-continuation byte abandons a partial sequence and skip mode.
            clear_decode();
            case (kind)
               KIND_LEAD1: begin
                  if (scalar_accepted({13'd0, b}, 3'd1)) begin
                     have = 1'b1;
                     cp   = {13'd0, b};
                  end
               end
               KIND_LEAD2: begin
                  partial    = {16'd0, b[4:0]};
                  seq_len    = 3'd2;
                  bytes_left = 2'd1;
               end
               KIND_LEAD3: begin
                  partial    = {17'd0, b[3:0]};
                  seq_len    = 3'd3;
                  bytes_left = 2'd2;
               end
               KIND_LEAD4: begin
                  partial    = {18'd0, b[2:0]};
                  seq_len    = 3'd4;
                  bytes_left = 2'd3;
               end
               default: skipping = 1'b1;
            endcase
         end
         if (last) begin
            d.code_point  = have ? cp : '0;
            d.point_valid = have;
            d.string_end  = 1'b1;
            points_due.push_back(d);
            clear_decode();
         end else if (have) begin
            d.code_point  = cp;
            d.point_valid = 1'b1;
            d.string_end  = 1'b0;
            points_due.push_back(d);
         end
      endfunction

      task report_mismatch(string what);
         $display("%0t ns mismatch: %s", $time, what);
         mismatch_count++;
      endtask

      task check_response(logic [20:0] cp, logic pv, logic se);
         decoded_point_type d;
         if (points_due.size() == 0) begin
            report_mismatch($sformatf("unexpected response cp=%h valid=%b end=%b", cp, pv, se));
         end else begin
            d = points_due.pop_front();
            if (cp !== d.code_point)
               report_mismatch($sformatf("code_point %h, wanted %h", cp, d.code_point));
            if (pv !== d.point_valid)
               report_mismatch($sformatf("point_valid %b, wanted %b", pv, d.point_valid));
            if (se !== d.string_end)
               report_mismatch($sformatf("string_end %b, wanted %b", se, d.string_end));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [20:0] rsp_code_point;
   logic        rsp_point_valid;
   logic        rsp_string_end;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   bit          hold_off = 1'b0;
   int          random_sent;

   utf8_decode_scoreboard sb = new();

   // Code points on or next to every boundary that decides acceptance.
   logic [20:0] boundary_points[17] = '{
      21'h000000, 21'h00007F, 21'h000080, 21'h0007FF, 21'h000800, 21'h00D7FF,
      21'h00D800, 21'h00DFFF, 21'h00E000, 21'h00FFFC, 21'h00FFFD, 21'h00FFFE,
      21'h00FFFF, 21'h010000, 21'h10FFFF, 21'h110000, 21'h1FFFFF
   };

   // Bit 8 marks the last byte of a string.
   logic [8:0] directed_bytes[25] = '{
      9'h000, 9'h07F,                  // extremes of the 1-byte range
      9'h0C0, 9'h080,                  // overlong 2-byte form
      9'h0ED, 9'h0A0, 9'h080,          // surrogate
      9'h0EF, 9'h0BF, 9'h0BD,          // replacement character
      9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,  // highest scalar value
      9'h0E0, 9'h0C3, 9'h0A9,          // lead arrives too early
      9'h0FF, 9'h080, 9'h041,          // invalid byte, skipped continuation
      9'h080,                          // stray continuation
      9'h0C3, 9'h1A9,                  // string ends on a complete character
      9'h0F0, 9'h19F                   // string ends inside a sequence
   };

   utf8_stream_decoder u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_point_valid (rsp_point_valid),
      .rsp_string_end  (rsp_string_end)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_data_byte, req_last_byte);
         if (rsp_valid && !rsp_stall)
            sb.check_response(rsp_code_point, rsp_point_valid, rsp_string_end);
      end
   end

   // Offers one request and returns at the falling edge after it is taken.
   task automatic send_request(input logic [7:0] b, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_random_byte(input logic [7:0] b);
      send_request(b, $urandom_range(0, 24) == 0);
      random_sent++;
   endtask

   // Sends the first 'keep' bytes of the len-byte encoding of v.
   task automatic send_encoded(input logic [20:0] v, input int len, input int keep);
      logic [7:0] b;
      for (int i = 0; i < keep; i++) begin
         if (i == 0) begin
            case (len)
               1: b = {1'b0, v[6:0]};
               2: b = {3'b110, v[10:6]};
               3: b = {4'b1110, v[15:12]};
               default: b = {5'b11110, v[20:18]};
            endcase
         end else begin
            b = {2'b10, v[6 * (len - 1 - i) +: 6]};
         end
         send_random_byte(b);
      end
   endtask

   task automatic send_random_sequence();
      int          pick;
      int          len;
      logic [20:0] v;
      pick = $urandom_range(0, 99);
      len  = $urandom_range(1, 4);
      if ($urandom_range(0, 9) < 3)
         v = boundary_points[$urandom_range(0, 16)];
      else
         v = 21'($urandom_range(0,
                 (1 << (len == 1 ? 7 : 5 * 1 + 6 * (len - 1) - len + 2)) - 1));
      if (pick < 60) begin
         send_encoded(v, len, len);
      end else if (pick < 75) begin
         // Cut short, so the next lead byte arrives too early.
         send_encoded(v, len == 1 ? 2 : len, $urandom_range(1, len == 1 ? 1 : len - 1));
      end else if (pick < 85) begin
         send_random_byte(8'hF8 | 8'($urandom_range(0, 7)));
         repeat ($urandom_range(0, 3)) send_random_byte(8'h80 | 8'($urandom_range(0, 63)));
      end else if (pick < 92) begin
         repeat ($urandom_range(1, 2)) send_random_byte(8'h80 | 8'($urandom_range(0, 63)));
      end else begin
         send_random_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic wait_drained();
      while (sb.points_due.size() != 0) @(negedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 12;
      recv_idle_pct = 71;
      foreach (directed_bytes[i])
         send_request(directed_bytes[i][7:0], directed_bytes[i][8]);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 12;
               recv_idle_pct = 71;
            end
            1: begin
               send_idle_pct = 71;
               recv_idle_pct = 12;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               // The receiver holds off long enough for the queue to fill and
               // push back on the request side.
               fork
                  begin
                     hold_off = 1'b1;
                     repeat (80) @(negedge clock);
                     hold_off = 1'b0;
                  end
               join_none
            end
         endcase
         random_sent = 0;
         while (random_sent < 150) send_random_sequence();
         req_valid <= 1'b0;
         wait_drained();
      end

      repeat (10) @(negedge clock);
      if (sb.mismatch_count == 0)
         $display("utf8_stream_decoder verification clean");
      else
         $display("utf8_stream_decoder verification failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("utf8_stream_decoder verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/u8d_pkg.sv
rtl/core/u8d_front.sv
rtl/core/u8d_back.sv
rtl/core/utf8_stream_decoder.sv
tb/sv/tb_utf8_stream_decoder.sv
